// ===== rtl/core/potential_field_point_evaluator_defines.svh =====
// assertion macros used by the potential field evaluator checker
// no dependencies; included by the checker file
`ifndef POTENTIAL_FIELD_POINT_EVALUATOR_DEFINES_SVH
`define POTENTIAL_FIELD_POINT_EVALUATOR_DEFINES_SVH

// same-cycle implication, off while reset is low
`define PFPE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define PFPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define PFPE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pfpe_pkg.sv =====
// widths, codes and shared types of the potential field point evaluator
// no dependencies; imported by every module of the block
package pfpe_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int POT_WIDTH   = 32;

    localparam int KIND_W     = 3;
    localparam int SIZE_W     = 16;
    localparam int LEVEL_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // clamped distance magnitude and compare widths
    localparam int DIST_W = 16;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > DIST_W + 1) ? DIFF_W : DIST_W + 1;
    localparam int SLIT_W = CMP_W + 1;

    localparam int PROD_W = SIZE_W + DIST_W;
    localparam int SQ_W   = 2 * PROD_W;
    localparam int A2_W   = 2 * SIZE_W;
    localparam int R2_W   = 2 * DIST_W + 1;
    localparam int RR_W   = ((R2_W > A2_W) ? R2_W : A2_W) + 1;

    // harmonic rounding: half of the Q.32 square products back to Q.8
    localparam int HARM_SHIFT = 25;
    localparam int HARM_W     = SQ_W + 1 - HARM_SHIFT;

    // coulomb root and divide
    localparam int FRAC_SHIFT = 16;
    localparam int ROOT_IN_W  = RR_W + FRAC_SHIFT;
    localparam int ROOT_W     = (ROOT_IN_W + 1) / 2;
    localparam int SQ_REM_W   = ROOT_W + 1;
    localparam int NUM_W      = LEVEL_W + FRAC_SHIFT + 1;
    localparam int DIV_SKIP   = FRAC_SHIFT / 2;
    localparam int QUO_W      = NUM_W - DIV_SKIP;
    localparam int DIV_REM_W  = ROOT_W;

    localparam int TERM_W = ((HARM_W > QUO_W) ? HARM_W : QUO_W) + 2;
    localparam int SUM_W  = ((TERM_W > POT_WIDTH) ? TERM_W : POT_WIDTH) + 1;

    // pipeline layout
    localparam int FRONT_STAGES = 4;
    localparam int SQRT_STAGES  = ROOT_IN_W / 2;
    localparam int DIV_STAGES   = QUO_W + 1;
    localparam int SQRT_FIRST   = FRONT_STAGES;
    localparam int DIV_FIRST    = SQRT_FIRST + SQRT_STAGES;
    localparam int SEL_STAGE    = DIV_FIRST + DIV_STAGES;
    localparam int OUT_STAGE    = SEL_STAGE + 1;
    localparam int N_STAGES     = OUT_STAGE + 1;

    localparam int IN_DATA_W  = ((2 * COORD_WIDTH + POT_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((POT_WIDTH + 7) / 8) * 8;

    localparam logic [DIST_W-1:0]    DIST_MAX = {DIST_W{1'b1}};
    localparam logic [POT_WIDTH-1:0] POT_MAX  = {1'b0, {(POT_WIDTH - 1){1'b1}}};
    localparam logic [POT_WIDTH-1:0] POT_MIN  = {1'b1, {(POT_WIDTH - 1){1'b0}}};

    // well shapes
    localparam logic [KIND_W-1:0] KIND_FREE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HARMONIC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BOX      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BARRIER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SLIT     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DISC     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_COULOMB  = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WELL_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_A    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_B    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_C    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL     = 3'd6;

    localparam logic [SIZE_W-1:0]  SIZE_A_RST = 16'd256;
    localparam logic [SIZE_W-1:0]  SIZE_B_RST = 16'd256;
    localparam logic [SIZE_W-1:0]  SIZE_C_RST = 16'd205;
    localparam logic [LEVEL_W-1:0] LEVEL_RST  = 31'd2560;

    // what an item carries past the root and divide stages
    typedef struct packed {
        logic signed [POT_WIDTH-1:0] acc;
        logic signed [TERM_W-1:0]    term;
        logic                        is_coul;
        logic                        force_min;
    } side_t;

endpackage

// ===== rtl/core/pfpe_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
// depends on pfpe_pkg; stage enables come from the top level valid chain
module pfpe_sqrt_pipe import pfpe_pkg::*; (
    input  logic                   aclk,
    input  logic [SQRT_STAGES-1:0] stage_en,
    input  logic [ROOT_IN_W-1:0]   rad_in,
    input  side_t                  side_in,
    output logic [ROOT_W-1:0]      root_out,
    output side_t                  side_out
);

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_state_t;

    function automatic sq_state_t sqrt_step(input logic [SQ_REM_W-1:0] rem,
                                            input logic [ROOT_W-1:0]   root,
                                            input logic [1:0]          pair);
        logic [SQ_REM_W+1:0] rem_s;
        logic [SQ_REM_W+1:0] trial;
        sq_state_t           res;
        rem_s = {rem, pair};
        trial = {1'b0, root, 2'b01};
        if (rem_s >= trial) begin
            res.rem  = SQ_REM_W'(rem_s - trial);
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_s[SQ_REM_W-1:0];
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    logic [SQ_REM_W-1:0]  rem_reg  [SQRT_STAGES-1];
    logic [ROOT_W-1:0]    root_reg [SQRT_STAGES-1];
    logic [ROOT_IN_W-1:0] rad_reg  [SQRT_STAGES-1];
    side_t                side_reg [SQRT_STAGES];
    logic [ROOT_W-1:0]    root_last_reg;

    sq_state_t            step_next [SQRT_STAGES-1];
    logic [ROOT_IN_W-1:0] rad_next  [SQRT_STAGES-1];
    sq_state_t            last_next;

    always_comb begin
        step_next[0] = sqrt_step('0, '0, rad_in[ROOT_IN_W-1 -: 2]);
        rad_next[0]  = rad_in << 2;
        for (int i = 1; i < SQRT_STAGES - 1; i++) begin
            step_next[i] = sqrt_step(rem_reg[i-1], root_reg[i-1],
                                     rad_reg[i-1][ROOT_IN_W-1 -: 2]);
            rad_next[i]  = rad_reg[i-1] << 2;
        end
        last_next = sqrt_step(rem_reg[SQRT_STAGES-2], root_reg[SQRT_STAGES-2],
                              rad_reg[SQRT_STAGES-2][ROOT_IN_W-1 -: 2]);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SQRT_STAGES - 1; i++) begin
            if (stage_en[i]) begin
                rem_reg[i]  <= step_next[i].rem;
                root_reg[i] <= step_next[i].root;
                rad_reg[i]  <= rad_next[i];
            end
        end
        if (stage_en[SQRT_STAGES-1]) begin
            root_last_reg <= last_next.root;
        end
        if (stage_en[0]) begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < SQRT_STAGES; i++) begin
            if (stage_en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign root_out = root_last_reg;
    assign side_out = side_reg[SQRT_STAGES-1];

endmodule

// ===== rtl/core/pfpe_div_pipe.sv =====
// coulomb magnitude: rounded level / root, restoring divide, one quotient bit a stage
// depends on pfpe_pkg; stage enables come from the top level valid chain
module pfpe_div_pipe import pfpe_pkg::*; (
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] stage_en,
    input  logic [ROOT_W-1:0]     root_in,
    input  logic [LEVEL_W-1:0]    level,
    input  side_t                 side_in,
    output logic [QUO_W-1:0]      quo_out,
    output side_t                 side_out
);

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic                 qbit;
    } dv_state_t;

    function automatic dv_state_t div_step(input logic [DIV_REM_W-1:0] rem,
                                           input logic                 nbit,
                                           input logic [DIV_REM_W-1:0] dvs);
        logic [DIV_REM_W:0] rem_s;
        dv_state_t          res;
        rem_s = {rem, nbit};
        if (rem_s >= {1'b0, dvs}) begin
            res.rem  = DIV_REM_W'(rem_s - {1'b0, dvs});
            res.qbit = 1'b1;
        end else begin
            res.rem  = rem_s[DIV_REM_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

    logic [DIV_REM_W-1:0] rem_reg  [DIV_STAGES-1];
    logic [QUO_W-1:0]     numb_reg [DIV_STAGES-1];
    logic [DIV_REM_W-1:0] dvs_reg  [DIV_STAGES-1];
    logic [QUO_W-1:0]     quo_reg  [DIV_STAGES];
    side_t                side_reg [DIV_STAGES];

    logic [NUM_W-1:0]     num_next;
    dv_state_t            step_next [DIV_STAGES];

    // level * 2^16 plus half the divisor gives round half up
    assign num_next = NUM_W'({level, {FRAC_SHIFT{1'b0}}}) + NUM_W'(root_in >> 1);

    always_comb begin
        step_next[0] = '0;
        for (int i = 1; i < DIV_STAGES; i++) begin
            step_next[i] = div_step(rem_reg[i-1], numb_reg[i-1][QUO_W-1], dvs_reg[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            // quotient bits above QUO_W are zero since the root is at least 2^8
            rem_reg[0]  <= DIV_REM_W'(num_next[NUM_W-1:QUO_W]);
            numb_reg[0] <= num_next[QUO_W-1:0];
            dvs_reg[0]  <= root_in;
            quo_reg[0]  <= '0;
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < DIV_STAGES - 1; i++) begin
            if (stage_en[i]) begin
                rem_reg[i]  <= step_next[i].rem;
                numb_reg[i] <= numb_reg[i-1] << 1;
                dvs_reg[i]  <= dvs_reg[i-1];
            end
        end
        for (int i = 1; i < DIV_STAGES; i++) begin
            if (stage_en[i]) begin
                quo_reg[i]  <= {quo_reg[i-1][QUO_W-2:0], step_next[i].qbit};
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign quo_out  = quo_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule

// ===== rtl/core/potential_field_point_evaluator.sv =====
// Potential field point evaluator: takes one grid point and the potential summed so far,
// adds the configured well shape at that point and saturates to the signed Q23.8 range.
// One item enters per clock unless the output stalls; every item passes all stages,
// whatever its well shape, with the 25-stage square root and the 41-stage divider of
// the softened coulomb shape. Results leave in input order. While the output waits, each
// empty stage pulls in the item behind it, so the input takes an item only after the
// first stage has handed on the last one, until the pipeline is full and stalls. The user
// must write configuration only while no item is in flight; the block does not enforce it.
// depends on pfpe_pkg, pfpe_sqrt_pipe and pfpe_div_pipe
module potential_field_point_evaluator import pfpe_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // x_coord, y_coord, acc_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // acc_out
    output logic                  m_tuser    // saturated
);

    // configuration registers
    logic [KIND_W-1:0]             kind_reg;
    logic signed [COORD_WIDTH-1:0] center_x_reg;
    logic signed [COORD_WIDTH-1:0] center_y_reg;
    logic [SIZE_W-1:0]             size_a_reg;
    logic [SIZE_W-1:0]             size_b_reg;
    logic [SIZE_W-1:0]             size_c_reg;
    logic [LEVEL_W-1:0]            level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= KIND_FREE;
            center_x_reg <= '0;
            center_y_reg <= '0;
            size_a_reg   <= SIZE_A_RST;
            size_b_reg   <= SIZE_B_RST;
            size_c_reg   <= SIZE_C_RST;
            level_reg    <= LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WELL_KIND: kind_reg     <= cfg_wdata[KIND_W-1:0];
                REG_CENTER_X:  center_x_reg <= cfg_wdata[COORD_WIDTH-1:0];
                REG_CENTER_Y:  center_y_reg <= cfg_wdata[COORD_WIDTH-1:0];
                REG_SIZE_A:    size_a_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_SIZE_B:    size_b_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_SIZE_C:    size_c_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_LEVEL:     level_reg    <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // valid chain: a stage loads when the output moves or is empty, or when the stage is empty
    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] valid_next;
    logic [N_STAGES-1:0] stage_en;
    logic [N_STAGES-1:0] valid_prev;
    logic [N_STAGES-1:0] taken;
    logic                advance;

    assign advance    = !valid_reg[OUT_STAGE] || m_tready;
    assign stage_en   = {N_STAGES{advance}} | ~valid_reg;
    assign valid_prev = {valid_reg[N_STAGES-2:0], s_tvalid};
    assign taken      = {m_tready, stage_en[N_STAGES-1:1]};

    always_comb begin
        for (int i = 0; i < N_STAGES; i++) begin
            valid_next[i] = stage_en[i] ? valid_prev[i] : (valid_reg[i] && !taken[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];

    // stage 0: distances and slit test
    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [POT_WIDTH-1:0]   acc_in;
    logic signed [DIFF_W-1:0]      dx;
    logic signed [DIFF_W-1:0]      dy;
    logic [DIFF_W-1:0]             mag_x;
    logic [DIFF_W-1:0]             mag_y;
    logic [CMP_W-1:0]              mag_x_ext;
    logic [CMP_W-1:0]              mag_y_ext;
    logic signed [SLIT_W-1:0]      y2;
    logic signed [SLIT_W-1:0]      d1;
    logic signed [SLIT_W-1:0]      d2;
    logic [SLIT_W-1:0]             a1;
    logic [SLIT_W-1:0]             a2;
    logic [DIST_W-1:0]             st0_adx_next;
    logic [DIST_W-1:0]             st0_ady_next;
    logic                          st0_slit_next;

    assign x_in   = s_tdata[COORD_WIDTH-1:0];
    assign y_in   = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign acc_in = s_tdata[2*COORD_WIDTH+POT_WIDTH-1:2*COORD_WIDTH];

    assign dx        = DIFF_W'(x_in) - DIFF_W'(center_x_reg);
    assign dy        = DIFF_W'(y_in) - DIFF_W'(center_y_reg);
    assign mag_x     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign mag_y     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    assign mag_x_ext = CMP_W'(mag_x);
    assign mag_y_ext = CMP_W'(mag_y);
    assign st0_adx_next = (mag_x_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : mag_x_ext[DIST_W-1:0];
    assign st0_ady_next = (mag_y_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : mag_y_ext[DIST_W-1:0];

    // slits sit at y = +-size_b/2 regardless of center_y
    assign y2 = SLIT_W'(y_in) <<< 1;
    assign d1 = y2 - $signed(SLIT_W'(size_b_reg));
    assign d2 = y2 + $signed(SLIT_W'(size_b_reg));
    assign a1 = d1[SLIT_W-1] ? SLIT_W'(-d1) : SLIT_W'(d1);
    assign a2 = d2[SLIT_W-1] ? SLIT_W'(-d2) : SLIT_W'(d2);
    assign st0_slit_next = (a1 <= SLIT_W'(size_c_reg)) || (a2 <= SLIT_W'(size_c_reg));

    logic [DIST_W-1:0]           st0_adx_reg;
    logic [DIST_W-1:0]           st0_ady_reg;
    logic                        st0_slit_reg;
    logic signed [POT_WIDTH-1:0] st0_acc_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            st0_adx_reg  <= st0_adx_next;
            st0_ady_reg  <= st0_ady_next;
            st0_slit_reg <= st0_slit_next;
            st0_acc_reg  <= acc_in;
        end
    end

    // stage 1: first products and compare flags
    logic [PROD_W-1:0]           st1_px_reg;
    logic [PROD_W-1:0]           st1_py_reg;
    logic [PROD_W-1:0]           st1_sqx_reg;
    logic [PROD_W-1:0]           st1_sqy_reg;
    logic [A2_W-1:0]             st1_a2_reg;
    logic                        st1_box_reg;
    logic                        st1_wall_reg;
    logic                        st1_slit_reg;
    logic signed [POT_WIDTH-1:0] st1_acc_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            st1_px_reg   <= PROD_W'(size_a_reg) * PROD_W'(st0_adx_reg);
            st1_py_reg   <= PROD_W'(size_b_reg) * PROD_W'(st0_ady_reg);
            st1_sqx_reg  <= PROD_W'(st0_adx_reg) * PROD_W'(st0_adx_reg);
            st1_sqy_reg  <= PROD_W'(st0_ady_reg) * PROD_W'(st0_ady_reg);
            st1_a2_reg   <= A2_W'(size_a_reg) * A2_W'(size_a_reg);
            st1_box_reg  <= (st0_adx_reg > size_a_reg) || (st0_ady_reg > size_b_reg);
            st1_wall_reg <= {st0_adx_reg, 1'b0} <= {1'b0, size_a_reg};
            st1_slit_reg <= st0_slit_reg;
            st1_acc_reg  <= st0_acc_reg;
        end
    end

    // stage 2: squares for the harmonic shape, squared radius
    logic [SQ_W-1:0]             st2_qx_reg;
    logic [SQ_W-1:0]             st2_qy_reg;
    logic [R2_W-1:0]             st2_r2_reg;
    logic [A2_W-1:0]             st2_a2_reg;
    logic                        st2_box_reg;
    logic                        st2_wall_reg;
    logic                        st2_slit_reg;
    logic signed [POT_WIDTH-1:0] st2_acc_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            st2_qx_reg   <= SQ_W'(st1_px_reg) * SQ_W'(st1_px_reg);
            st2_qy_reg   <= SQ_W'(st1_py_reg) * SQ_W'(st1_py_reg);
            st2_r2_reg   <= R2_W'(st1_sqx_reg) + R2_W'(st1_sqy_reg);
            st2_a2_reg   <= st1_a2_reg;
            st2_box_reg  <= st1_box_reg;
            st2_wall_reg <= st1_wall_reg;
            st2_slit_reg <= st1_slit_reg;
            st2_acc_reg  <= st1_acc_reg;
        end
    end

    // stage 3: pick the term of every shape but coulomb, form the root operand
    logic [SQ_W:0]          harm_sum;
    logic [HARM_W-1:0]      harm_term;
    logic [RR_W-1:0]        rr;
    logic signed [TERM_W-1:0] term_pre;
    side_t                  st3_side_next;

    assign harm_sum  = (SQ_W+1)'(st2_qx_reg) + (SQ_W+1)'(st2_qy_reg)
                     + ((SQ_W+1)'(1) << (HARM_SHIFT - 1));
    assign harm_term = harm_sum[SQ_W:HARM_SHIFT];
    assign rr        = RR_W'(st2_r2_reg) + RR_W'(st2_a2_reg);

    always_comb begin
        term_pre = '0;
        unique case (kind_reg)
            KIND_HARMONIC: term_pre = TERM_W'(harm_term);
            KIND_BOX:      term_pre = st2_box_reg ? TERM_W'(level_reg) : '0;
            KIND_BARRIER:  term_pre = st2_wall_reg ? TERM_W'(level_reg) : '0;
            KIND_SLIT:     term_pre = (st2_wall_reg && !st2_slit_reg) ?
                                      TERM_W'(level_reg) : '0;
            KIND_DISC:     term_pre = (st2_r2_reg <= R2_W'(st2_a2_reg)) ?
                                      -TERM_W'(level_reg) : '0;
            default:       term_pre = '0;
        endcase
        st3_side_next.acc       = st2_acc_reg;
        st3_side_next.term      = term_pre;
        st3_side_next.is_coul   = (kind_reg == KIND_COULOMB);
        // zero radius with zero softening has no divisor
        st3_side_next.force_min = (kind_reg == KIND_COULOMB) && (rr == '0);
    end

    side_t                st3_side_reg;
    logic [ROOT_IN_W-1:0] st3_rad_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            st3_side_reg <= st3_side_next;
            st3_rad_reg  <= {rr, {FRAC_SHIFT{1'b0}}};
        end
    end

    logic [ROOT_W-1:0] root;
    side_t             sqrt_side;
    logic [QUO_W-1:0]  quo;
    side_t             div_side;

    pfpe_sqrt_pipe u_sqrt (
        .aclk     (aclk),
        .stage_en (stage_en[SQRT_FIRST +: SQRT_STAGES]),
        .rad_in   (st3_rad_reg),
        .side_in  (st3_side_reg),
        .root_out (root),
        .side_out (sqrt_side)
    );

    pfpe_div_pipe u_div (
        .aclk     (aclk),
        .stage_en (stage_en[DIV_FIRST +: DIV_STAGES]),
        .root_in  (root),
        .level    (level_reg),
        .side_in  (sqrt_side),
        .quo_out  (quo),
        .side_out (div_side)
    );

    // select stage
    logic signed [POT_WIDTH-1:0] sel_acc_reg;
    logic signed [TERM_W-1:0]    sel_term_reg;
    logic                        sel_force_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[SEL_STAGE]) begin
            sel_acc_reg   <= div_side.acc;
            sel_term_reg  <= div_side.is_coul ? -TERM_W'(quo) : div_side.term;
            sel_force_reg <= div_side.force_min;
        end
    end

    // output stage: add and clip
    logic [SUM_W-1:0]     sum;
    logic                 over_hi;
    logic                 over_lo;
    logic [POT_WIDTH-1:0] acc_out_next;
    logic                 sat_next;

    assign sum     = SUM_W'(sel_acc_reg) + SUM_W'(sel_term_reg);
    assign over_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:POT_WIDTH-1]);
    assign over_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:POT_WIDTH-1]);

    always_comb begin
        priority if (sel_force_reg) begin
            acc_out_next = POT_MIN;
            sat_next     = 1'b1;
        end else if (over_hi) begin
            acc_out_next = POT_MAX;
            sat_next     = 1'b1;
        end else if (over_lo) begin
            acc_out_next = POT_MIN;
            sat_next     = 1'b1;
        end else begin
            acc_out_next = sum[POT_WIDTH-1:0];
            sat_next     = 1'b0;
        end
    end

    logic [POT_WIDTH-1:0] acc_out_reg;
    logic                 sat_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[OUT_STAGE]) begin
            acc_out_reg <= acc_out_next;
            sat_reg     <= sat_next;
        end
    end

    assign m_tvalid = valid_reg[OUT_STAGE];
    assign m_tdata  = OUT_DATA_W'(acc_out_reg);
    assign m_tuser  = sat_reg;

endmodule

// ===== rtl/core/pfpe_checker.sv =====
// port-level checks of the potential field point evaluator, bound to the top level
// depends on pfpe_pkg and potential_field_point_evaluator_defines.svh
`include "potential_field_point_evaluator_defines.svh"

module pfpe_checker import pfpe_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    `PFPE_ASSERT_NEXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_tvalid, "item out of reset")

    `PFPE_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "item dropped")

    `PFPE_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled item changed")

    `PFPE_ASSERT_IMPL(a_sat_at_bound, aclk, aresetn, m_tvalid && m_tuser, (m_tdata[POT_WIDTH-1:0] == POT_MAX) || (m_tdata[POT_WIDTH-1:0] == POT_MIN), "saturated item not at a bound")

    `PFPE_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

bind potential_field_point_evaluator pfpe_checker u_pfpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb_potential_field_point_evaluator.sv =====
`timescale 1ns / 100ps
// testbench for potential_field_point_evaluator: streams grid points through every well
// shape under many register settings and checks each result against an in-bench model
// depends on pfpe_pkg and the evaluator rtl
module tb_potential_field_point_evaluator;
    import pfpe_pkg::*;

    localparam int POINT_TARGET = 1950;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PIPE_DEPTH   = 80;
    localparam int LONG_HOLD    = 400;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
    localparam logic [KIND_W-1:0]    KIND_SPARE = 3'd7;

    localparam longint          POT_HI      = (longint'(1) << (POT_WIDTH - 1)) - 1;
    localparam longint          POT_LO      = -POT_HI - 1;
    localparam longint unsigned DIST_CLAMP  = 64'hFFFF;
    localparam longint unsigned ROUND_MASK  = (64'd1 << HARM_SHIFT) - 1;

    typedef struct {
        int unsigned          seq;
        logic [POT_WIDTH-1:0] acc;
        logic                 sat;
    } field_sum_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // x_coord, y_coord, acc_in
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // acc_out
    logic                  m_tuser;          // saturated

    // register copy used for prediction
    logic [KIND_W-1:0] well_kind_q = KIND_FREE;
    longint            ctr_x       = 0;
    longint            ctr_y       = 0;
    longint unsigned   size_a      = 256;
    longint unsigned   size_b      = 256;
    longint unsigned   size_c      = 205;
    longint unsigned   well_level  = 2560;

    logic [IN_DATA_W-1:0] point_q[$];
    field_sum_t           sum_q[$];

    int          gap_left     = 0;
    int          hold_left    = 0;
    int          hold_request = 0;
    bit          src_gaps     = 1'b0;
    bit          sink_stalls  = 1'b0;
    bit          point_taken  = 1'b0;
    int unsigned points_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned sat_seen     = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned settings_used = 0;

    always #6 aclk = ~aclk;

    potential_field_point_evaluator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic field_sum_t field_at(logic [IN_DATA_W-1:0] pt);
        longint          x, y, acc, dx, dy, term, total, d1, d2;
        longint unsigned adx, ady, r2, px, py, qx, qy, lo, rr, root, mag, a1, a2;
        logic            clip, force_min;
        field_sum_t      res;
        x   = $signed(pt[0 +: COORD_WIDTH]);
        y   = $signed(pt[COORD_WIDTH +: COORD_WIDTH]);
        acc = $signed(pt[2 * COORD_WIDTH +: POT_WIDTH]);
        dx  = x - ctr_x;
        dy  = y - ctr_y;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (adx > DIST_CLAMP) adx = DIST_CLAMP;
        if (ady > DIST_CLAMP) ady = DIST_CLAMP;
        r2 = adx * adx + ady * ady;
        term = 0;
        force_min = 1'b0;
        clip = 1'b0;
        case (well_kind_q)
            KIND_HARMONIC: begin
                px = size_a * adx;
                py = size_b * ady;
                qx = px * px;
                qy = py * py;
                // split keeps the half-up rounding exact without overflow
                lo = (qx & ROUND_MASK) + (qy & ROUND_MASK) + (64'd1 << (HARM_SHIFT - 1));
                term = (qx >> HARM_SHIFT) + (qy >> HARM_SHIFT) + (lo >> HARM_SHIFT);
            end
            KIND_BOX: begin
                if (adx > size_a || ady > size_b) term = well_level;
            end
            KIND_BARRIER: begin
                if (2 * adx <= size_a) term = well_level;
            end
            KIND_SLIT: begin
                // slits sit at y = +-size_b/2 regardless of center_y
                d1 = 2 * y - longint'(size_b);
                d2 = 2 * y + longint'(size_b);
                a1 = (d1 < 0) ? -d1 : d1;
                a2 = (d2 < 0) ? -d2 : d2;
                if (2 * adx <= size_a && a1 > size_c && a2 > size_c) term = well_level;
            end
            KIND_DISC: begin
                if (r2 <= size_a * size_a) term = -longint'(well_level);
            end
            KIND_COULOMB: begin
                rr = r2 + size_a * size_a;
                if (rr == 0) begin
                    force_min = 1'b1;
                end else begin
                    root = floor_root(rr << FRAC_SHIFT);
                    mag  = ((well_level << FRAC_SHIFT) + (root >> 1)) / root;
                    term = -longint'(mag);
                end
            end
            default: term = 0;
        endcase
        total = acc + term;
        if (force_min) begin
            total = POT_LO;
            clip = 1'b1;
        end else if (total > POT_HI) begin
            total = POT_HI;
            clip = 1'b1;
        end else if (total < POT_LO) begin
            total = POT_LO;
            clip = 1'b1;
        end
        res.seq = points_sent;
        res.acc = total[POT_WIDTH-1:0];
        res.sat = clip;
        return res;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_point(logic [COORD_WIDTH-1:0] x,
                                                        logic [COORD_WIDTH-1:0] y,
                                                        logic [POT_WIDTH-1:0] acc);
        return IN_DATA_W'({acc, y, x});
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
        return $urandom_range(15, 90);
    endfunction

    // coordinate close to the center or one of the shape's boundaries, or anywhere
    function automatic logic [COORD_WIDTH-1:0] near(longint ctr, longint unsigned span,
                                                    longint unsigned alt);
        longint reach;
        case ($urandom_range(0, 5))
            0: reach = 0;
            1: reach = span;
            2: reach = span / 2;
            3: reach = (span + alt) / 2;
            4: reach = (span > alt) ? (span - alt) / 2 : (alt - span) / 2;
            default: reach = $urandom_range(0, 4096);
        endcase
        if ($urandom_range(0, 1)) reach = -reach;
        case ($urandom_range(0, 9))
            0: return {1'b1, {(COORD_WIDTH - 1){1'b0}}};
            1: return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
            2, 3: return COORD_WIDTH'($urandom());
            default: return COORD_WIDTH'(ctr + reach + longint'($urandom_range(0, 6)) - 3);
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_point();
        logic [COORD_WIDTH-1:0] x, y;
        logic [POT_WIDTH-1:0]   acc;
        x = near(ctr_x, size_a, size_a);
        if (well_kind_q == KIND_SLIT) y = near(0, size_b, size_c);
        else y = near(ctr_y, size_b, size_b);
        case ($urandom_range(0, 7))
            0: acc = POT_MAX - POT_WIDTH'($urandom_range(0, 4096));
            1: acc = POT_MIN + POT_WIDTH'($urandom_range(0, 4096));
            2: acc = POT_WIDTH'($urandom_range(0, 8192)) - POT_WIDTH'(4096);
            default: acc = POT_WIDTH'($urandom());
        endcase
        return pack_point(x, y, acc);
    endfunction

    function automatic logic [COORD_WIDTH-1:0] pick_center();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(COORD_WIDTH - 1){1'b0}}};
            1: return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
            2: return '0;
            3: return COORD_WIDTH'($urandom());
            default: return COORD_WIDTH'($urandom_range(0, 4096)) - COORD_WIDTH'(2048);
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return SIZE_W'($urandom_range(0, 1024));
            default: return SIZE_W'($urandom());
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return LEVEL_W'($urandom_range(1, 100000));
            default: return LEVEL_W'($urandom());
        endcase
    endfunction

    // leaves the write enable high; set_well lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_WELL_KIND: well_kind_q = data[KIND_W-1:0];
            REG_CENTER_X:  ctr_x = $signed(data[COORD_WIDTH-1:0]);
            REG_CENTER_Y:  ctr_y = $signed(data[COORD_WIDTH-1:0]);
            REG_SIZE_A:    size_a = data[SIZE_W-1:0];
            REG_SIZE_B:    size_b = data[SIZE_W-1:0];
            REG_SIZE_C:    size_c = data[SIZE_W-1:0];
            REG_LEVEL:     well_level = data[LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // junk puts random bits above each narrower register's width and pokes the unused index
    task automatic set_well(logic [KIND_W-1:0] kind, logic [COORD_WIDTH-1:0] cx,
                            logic [COORD_WIDTH-1:0] cy, logic [SIZE_W-1:0] sa,
                            logic [SIZE_W-1:0] sb, logic [SIZE_W-1:0] sc,
                            logic [LEVEL_W-1:0] lvl, bit junk);
        logic [CFG_DATA_W-1:0] noise;
        noise = junk ? CFG_DATA_W'($urandom()) : '0;
        write_reg(REG_WELL_KIND, {noise[CFG_DATA_W-1:KIND_W], kind});
        write_reg(REG_CENTER_X, {noise[CFG_DATA_W-1:COORD_WIDTH], cx});
        write_reg(REG_CENTER_Y, {noise[CFG_DATA_W-1:COORD_WIDTH], cy});
        write_reg(REG_SIZE_A, {noise[CFG_DATA_W-1:SIZE_W], sa});
        write_reg(REG_SIZE_B, {noise[CFG_DATA_W-1:SIZE_W], sb});
        write_reg(REG_SIZE_C, {noise[CFG_DATA_W-1:SIZE_W], sc});
        write_reg(REG_LEVEL, lvl);
        if (junk) write_reg(REG_SPARE, noise);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        while (point_q.size() != 0 || s_tvalid || sum_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, int unsigned seq, longint unsigned got,
                                   longint unsigned want);
        $display("mismatch on item %0d, %s: got %h, want %h", seq, what, got, want);
        mismatches++;
    endtask

    // source side
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || point_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (point_q.size() != 0) begin
                s_tdata <= point_q.pop_front();
                s_tvalid <= 1'b1;
                if (src_gaps && $urandom_range(0, 99) < 25) gap_left = idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_request;
            hold_request = 0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            hold_left = idle_len();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // checks results, records accepted items and watches for a hang
    always @(posedge aclk) begin
        field_sum_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (sum_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", results_seen,
                                    m_tdata, 0);
                end else begin
                    want = sum_q.pop_front();
                    if (m_tdata[POT_WIDTH-1:0] !== want.acc)
                        report_mismatch("acc_out", want.seq, m_tdata[POT_WIDTH-1:0], want.acc);
                    if (m_tuser !== want.sat)
                        report_mismatch("saturated", want.seq, m_tuser, want.sat);
                    if (want.sat) sat_seen++;
                end
            end
            point_taken = s_tvalid && s_tready;
            if (point_taken) begin
                sum_q.push_back(field_at(s_tdata));
                points_sent++;
            end
            if (point_taken || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                $display("tb_potential_field_point_evaluator: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int count;
        int queued;
        logic [KIND_W-1:0] kind;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // free well at reset values, accumulator at its rails
        point_q.push_back(pack_point(16'h7fff, 16'h8000, POT_MAX));
        point_q.push_back(pack_point(16'h8000, 16'h7fff, POT_MIN));
        drain();

        // harmonic with the widest omegas overflows far away
        set_well(KIND_HARMONIC, '0, '0, 16'hffff, 16'hffff, SIZE_C_RST, LEVEL_RST, 1'b0);
        point_q.push_back(pack_point(16'h8000, 16'h8000, '0));
        point_q.push_back(pack_point('0, '0, POT_MIN));
        point_q.push_back(pack_point(16'h0100, 16'hff00, '0));
        drain();

        // box edges and a clipped wall
        set_well(KIND_BOX, 16'd100, 16'hff9c, 16'd256, 16'd512, SIZE_C_RST, '1, 1'b0);
        point_q.push_back(pack_point(16'd100, 16'hff9c, POT_MAX));
        point_q.push_back(pack_point(16'd356, 16'hff9c, '0));
        point_q.push_back(pack_point(16'd357, 16'hff9c, '0));
        point_q.push_back(pack_point(16'h7fff, '0, POT_MAX));
        drain();

        set_well(KIND_BARRIER, '0, '0, 16'd512, SIZE_B_RST, SIZE_C_RST, 31'd1000, 1'b0);
        point_q.push_back(pack_point(16'd256, '0, '0));
        point_q.push_back(pack_point(16'hfeff, '0, '0));
        drain();

        // center_y is ignored by the slit; upper slit middle, lower slit outer edge both sides
        set_well(KIND_SLIT, '0, 16'd3000, 16'hffff, 16'd1024, 16'd205, 31'd5000, 1'b0);
        point_q.push_back(pack_point('0, 16'd512, '0));
        point_q.push_back(pack_point('0, '0, '0));
        point_q.push_back(pack_point('0, 16'hfd9a, '0));
        point_q.push_back(pack_point('0, 16'hfd99, '0));
        drain();

        set_well(KIND_DISC, '0, '0, 16'd256, SIZE_B_RST, SIZE_C_RST, LEVEL_RST, 1'b0);
        point_q.push_back(pack_point(16'd256, '0, '0));
        point_q.push_back(pack_point(16'd181, 16'd182, '0));
        point_q.push_back(pack_point('0, '0, POT_MIN));
        drain();

        // zero softening: divide by zero at the center, huge pull next to it
        set_well(KIND_COULOMB, 16'd5, 16'd5, '0, SIZE_B_RST, SIZE_C_RST, '1, 1'b0);
        point_q.push_back(pack_point(16'd5, 16'd5, 32'd1234));
        point_q.push_back(pack_point(16'd6, 16'd5, '0));
        drain();

        // unused kind adds nothing; junk write to the unused index
        set_well(KIND_SPARE, 16'h1234, 16'h4321, 16'd77, 16'd88, 16'd99, 31'd12345, 1'b1);
        point_q.push_back(pack_point(16'h1234, 16'h4321, 32'h12345678));
        drain();

        queued = 21;
        phase = 0;
        while (queued < POINT_TARGET) begin
            kind = (phase < 8) ? KIND_W'(phase) : KIND_W'($urandom_range(0, 7));
            set_well(kind, pick_center(), pick_center(), pick_size(), pick_size(), pick_size(),
                     pick_level(), bit'($urandom_range(0, 1)));
            src_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            count = $urandom_range(50, 110);
            if (phase == 3) begin
                // sink holds off long enough for the pipeline to fill and back up
                src_gaps = 1'b0;
                count = 200;
                hold_request = LONG_HOLD;
            end
            repeat (count) point_q.push_back(random_point());
            queued += count;
            phase++;
            drain();
        end

        repeat (PIPE_DEPTH) @(posedge aclk);
        if (sum_q.size() != 0)
            report_mismatch("results never arrived", points_sent, sum_q.size(), 0);
        $display("covered %0d points under %0d well settings, every kind code incl. unused",
                 points_sent, settings_used);
        $display("%0d results clipped, %0d mismatches", sat_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_potential_field_point_evaluator: PASS");
        end else begin
            $display("tb_potential_field_point_evaluator: FAIL");
        end
        $finish;
    end

endmodule

// ===== potential_field_point_evaluator.f =====
+incdir+rtl/core
rtl/core/pfpe_pkg.sv
rtl/core/pfpe_sqrt_pipe.sv
rtl/core/pfpe_div_pipe.sv
rtl/core/potential_field_point_evaluator.sv
rtl/core/pfpe_checker.sv
tb/tb_potential_field_point_evaluator.sv
